@@ rtl/core/sha256_byte_stream_hasher_top_assert.svh @@
// Assertion macros shared by the hasher RTL.
// Every use samples on i_clk and is disabled while i_rst_n is low.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sha256bsh_pkg.sv @@
`default_nettype none

package sha256bsh_pkg;

    // One input word: a message byte with its flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } t_item;

    // One result word: the 256-bit digest, big-endian
    typedef struct packed {
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
    } t_digest;

    // Eight 32-bit words, index 0 is a / H0
    typedef logic [7:0][31:0] t_word8;

    // Sequencer to compression engine
    typedef struct packed {
        logic       shift;    // shift din into the block register
        logic [7:0] din;
        logic       start;    // begin 64 rounds on the block register
        logic       restart;  // chain back to initial hash values
    } t_eng_ctrl;

    // Compression engine to sequencer
    typedef struct packed {
        logic       busy;
        logic [5:0] round;
    } t_eng_stat;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LENGTH_POS  = 56;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  FILL_LAST   = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0]  LAST_ROUND  = 6'(63);

    // Initial hash values, element 0 is H0
    localparam t_word8 H_INIT = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    // Round constants
    localparam logic [31:0] K_ROUND [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

endpackage

`default_nettype wire

@@ rtl/core/sha256bsh_engine.sv @@
`default_nettype none
`include "sha256_byte_stream_hasher_top_assert.svh"

module sha256bsh_engine
    import sha256bsh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_eng_ctrl i_ctrl,
    output t_eng_stat      o_stat,
    output t_word8         o_chain
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_ROUND,
        E_FINAL
    } t_estate;

    t_estate      r_state;
    logic [5:0]   r_rnd;
    t_word8       r_chain;
    t_word8       r_v;
    // block register, doubles as the rolling schedule; word t sits at the top
    logic [511:0] r_blk;

    t_word8       n_v;
    logic [31:0]  w_t;
    logic [31:0]  w_new;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // schedule taps: w[t], w[t+1], w[t+9], w[t+14]
    always_comb begin
        logic [31:0] w1;
        logic [31:0] w9;
        logic [31:0] w14;
        logic [31:0] s0;
        logic [31:0] s1;
        w_t   = r_blk[511:480];
        w1    = r_blk[479:448];
        w9    = r_blk[223:192];
        w14   = r_blk[63:32];
        s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        w_new = w_t + s0 + w9 + s1;
    end

    // one compression round
    always_comb begin
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] big_s0;
        logic [31:0] big_s1;
        logic [31:0] ch;
        logic [31:0] maj;
        big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_s1 + ch + K_ROUND[r_rnd] + w_t;
        t2     = big_s0 + maj;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    // sequencer: idle (byte loading), 64 rounds, chain update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_rnd   <= '0;
            r_chain <= H_INIT;
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_ctrl.shift) begin
                        r_blk <= {r_blk[503:0], i_ctrl.din};
                    end
                    if (i_ctrl.restart) begin
                        r_chain <= H_INIT;
                    end
                    if (i_ctrl.start) begin
                        r_v     <= r_chain;
                        r_rnd   <= '0;
                        r_state <= E_ROUND;
                    end
                end
                E_ROUND: begin
                    r_v   <= n_v;
                    r_blk <= {r_blk[479:0], w_new};
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == LAST_ROUND) begin
                        r_state <= E_FINAL;
                    end
                end
                E_FINAL: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy  = (r_state != E_IDLE);
    assign o_stat.round = r_rnd;
    assign o_chain      = r_chain;

    `SHA_ASSERT_NOW(a_shift_only_idle, i_ctrl.shift, r_state == E_IDLE, "byte shifted while hashing")
    `SHA_ASSERT_NEXT(a_start_round0, i_ctrl.start && r_state == E_IDLE, r_state == E_ROUND && r_rnd == '0, "start did not enter round 0")
    `SHA_ASSERT_NEXT(a_final_after_last, r_state == E_ROUND && r_rnd == LAST_ROUND, r_state == E_FINAL, "missed chain update after last round")

endmodule

`default_nettype wire

@@ rtl/core/sha256_byte_stream_hasher_top.sv @@
`default_nettype none
`include "sha256_byte_stream_hasher_top_assert.svh"

// SHA-256 hasher taking one message byte per input word (last_byte ends the message,
// byte_valid low on a last word pads without adding a byte; byte_valid low otherwise
// is ignored) and returning the 256-bit digest as one output word of four big-endian
// 64-bit words. A byte is taken while ready is high, and ready stays high for the next one,
// except on every 64th byte, which holds ready low while the single shared round unit
// runs 64 rounds, one per cycle, and adds into the chaining words. On a last word the
// padding is shifted into the block register one byte per cycle (64 minus the fill, plus
// 64 more when a second block is needed), and each padded block is then hashed the same
// way, and no new byte is taken until the finished digest sits in the output register;
// a later digest waits only if that register has not been taken.

module sha256_byte_stream_hasher_top
    import sha256bsh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_digest    o_digest
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_HASH
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [63:0] r_msg;
    logic        r_last;     // padding follows the running compression
    logic        r_final;    // running compression holds the length field
    logic        r_mark;     // 0x80 already placed
    logic        r_lenblk;   // current pad block carries the length
    logic        r_out_valid;
    t_digest     r_out;

    t_eng_ctrl   w_ctrl;
    t_eng_stat   w_stat;
    t_word8      w_chain;

    logic        w_accept;
    logic        w_lenblk;
    logic        w_out_free;
    logic        w_deliver;
    logic [63:0] w_bits;
    logic [7:0]  w_len_byte;
    logic [7:0]  w_pad_byte;

    sha256bsh_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .o_chain (w_chain)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // padding byte for the current block position
    assign w_bits     = {r_msg[60:0], 3'b000};
    assign w_len_byte = w_bits[{3'(~r_fill[2:0]), 3'b000} +: 8];
    assign w_lenblk   = r_mark ? r_lenblk : (r_fill < 6'(LENGTH_POS));
    always_comb begin
        if (!r_mark) begin
            w_pad_byte = PAD_BYTE;
        end else if (w_lenblk && r_fill >= 6'(LENGTH_POS)) begin
            w_pad_byte = w_len_byte;
        end else begin
            w_pad_byte = '0;
        end
    end

    // digest hand-off
    assign w_out_free = !r_out_valid || i_ready;
    assign w_deliver  = (r_state == S_HASH) && !w_stat.busy && r_final && w_out_free;

    // engine control
    always_comb begin
        w_ctrl.shift   = (w_accept && i_item.byte_valid) || (r_state == S_PAD);
        w_ctrl.din     = (r_state == S_PAD) ? w_pad_byte : i_item.data_byte;
        w_ctrl.start   = ((w_accept && i_item.byte_valid) || (r_state == S_PAD))
                         && (r_fill == FILL_LAST);
        w_ctrl.restart = w_deliver;
    end

    // message sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_msg       <= '0;
            r_last      <= 1'b0;
            r_final     <= 1'b0;
            r_mark      <= 1'b0;
            r_lenblk    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load on delivery, clear once taken
            if (w_deliver) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.byte_valid) begin
                            r_fill <= r_fill + 6'd1;
                            r_msg  <= r_msg + 64'd1;
                        end
                        r_last  <= i_item.last_byte;
                        r_mark  <= 1'b0;
                        r_final <= 1'b0;
                        if (w_ctrl.start) begin
                            r_state <= S_HASH;
                        end else if (i_item.last_byte) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fill   <= r_fill + 6'd1;
                    r_mark   <= 1'b1;
                    r_lenblk <= w_lenblk;
                    if (r_fill == FILL_LAST) begin
                        r_final <= w_lenblk;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (!w_stat.busy) begin
                        if (r_final) begin
                            if (w_out_free) begin
                                r_out.digest_word0 <= {w_chain[0], w_chain[1]};
                                r_out.digest_word1 <= {w_chain[2], w_chain[3]};
                                r_out.digest_word2 <= {w_chain[4], w_chain[5]};
                                r_out.digest_word3 <= {w_chain[6], w_chain[7]};
                                r_fill      <= '0;
                                r_msg       <= '0;
                                r_final     <= 1'b0;
                                r_last      <= 1'b0;
                                r_state     <= S_IDLE;
                            end
                        end else if (r_last) begin
                            // a second pad block always carries the length
                            r_lenblk <= 1'b1;
                            r_state  <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_digest = r_out;

    `SHA_ASSERT_NOW(a_ready_engine_idle, o_ready, !w_stat.busy, "ready while engine busy")
    `SHA_ASSERT_NOW(a_start_on_full, w_ctrl.start, r_fill == FILL_LAST, "compression started on partial block")
    `SHA_ASSERT_NEXT(a_deliver_valid, w_deliver, o_valid && r_state == S_IDLE, "digest not presented")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sha256bsh_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 400;   // extra wait after the last expected digest, to catch a stray one
    localparam int TARGET_ITEMS = 2000;
    localparam int MIN_DIGESTS  = 40;
    localparam int MAX_REPORTS  = 10;

    localparam int         BLK_LEN       = 64;
    localparam int         LEN_FIELD_POS = 56;
    localparam logic [7:0] PAD_MARK      = 8'h80;

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef enum int {RX_STEADY, RX_JITTER, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    function automatic logic [31:0] rotr32(logic [31:0] x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Running SHA-256 of the byte stream; queues one digest per closed message
    class digest_scoreboard;
        logic [7:0]  blk [BLK_LEN];
        logic [5:0]  fill;
        logic [63:0] msg_len;
        logic [31:0] chain [8];
        t_digest     expected_q [$];
        int          fault_count;

        function new();
            fault_count = 0;
            foreach (blk[i]) blk[i] = '0;
            restart();
        endfunction

        local function void restart();
            fill    = '0;
            msg_len = '0;
            foreach (chain[i]) chain[i] = SHA_H0[i];
        endfunction

        local function void compress_block();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] w15, w2, s0, s1, t1, t2, wt;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int r = 0; r < 64; r++) begin
                if (r < 16) begin
                    wt = w[r];
                end else begin
                    // rolling schedule: slots r-15, r-2, r-7 mod 16
                    w15 = w[(r + 1) % 16];
                    w2  = w[(r + 14) % 16];
                    s0  = rotr32(w15, 7) ^ rotr32(w15, 18) ^ (w15 >> 3);
                    s1  = rotr32(w2, 17) ^ rotr32(w2, 19) ^ (w2 >> 10);
                    wt  = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
                    w[r % 16] = wt;
                end
                t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25)) +
                     ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wt;
                t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22)) +
                     ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] = chain[i] + v[i];
        endfunction

        function void log_fault(string what);
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("%s", what);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Accepted input word
        function void note_word(t_item w);
            int          pos;
            logic [63:0] bit_len;
            t_digest     dg;
            if (w.byte_valid) begin
                blk[fill] = w.data_byte;
                msg_len   = msg_len + 1;
                fill      = fill + 1;
                if (fill == 0)
                    compress_block();
            end
            if (!w.last_byte)
                return;

            // padding: marker, zeros, 64-bit bit count
            pos      = fill;
            blk[pos] = PAD_MARK;
            pos++;
            if (pos > LEN_FIELD_POS) begin
                while (pos < BLK_LEN) begin
                    blk[pos] = '0;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LEN_FIELD_POS) begin
                blk[pos] = '0;
                pos++;
            end
            bit_len = msg_len << 3;
            for (int i = 0; i < 8; i++)
                blk[BLK_LEN - 1 - i] = bit_len[8*i +: 8];
            compress_block();

            dg.digest_word0 = {chain[0], chain[1]};
            dg.digest_word1 = {chain[2], chain[3]};
            dg.digest_word2 = {chain[4], chain[5]};
            dg.digest_word3 = {chain[6], chain[7]};
            expected_q.push_back(dg);
            restart();
        endfunction

        // Accepted output word against the oldest expected digest
        function void check_digest(t_digest got);
            t_digest     want;
            logic [63:0] want_w [4];
            logic [63:0] got_w [4];
            if (expected_q.size() == 0) begin
                log_fault($sformatf("unexpected digest %h", got));
                return;
            end
            want = expected_q.pop_front();
            want_w = '{want.digest_word0, want.digest_word1,
                       want.digest_word2, want.digest_word3};
            got_w  = '{got.digest_word0, got.digest_word1,
                       got.digest_word2, got.digest_word3};
            for (int i = 0; i < 4; i++)
                if (got_w[i] !== want_w[i])
                    log_fault($sformatf("digest_word%0d mismatch: expected %h got %h",
                                        i, want_w[i], got_w[i]));
        endfunction

        function void flag_leftovers();
            foreach (expected_q[i])
                log_fault($sformatf("digest never delivered: %h", expected_q[i]));
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_item   i_item;
    logic    o_valid;
    logic    i_ready;
    t_digest o_digest;

    digest_scoreboard sb = new();

    int       idle_cycles = 0;
    bit       timed_out   = 1'b0;
    int       burst_left  = 0;
    int       sent_items  = 0;
    t_rx_mode rx_mode     = RX_STEADY;
    int       rx_left     = 0;
    int       rx_period   = 2;
    int       rx_phase    = 0;

    sha256_byte_stream_hasher_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_digest (o_digest)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver stall pattern: steady, jittery, periodic, sparse stretches
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_left   = $urandom_range(20, 300);
            rx_period = $urandom_range(2, 20);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_STEADY:   i_ready <= 1'b1;
            RX_JITTER:   i_ready <= ($urandom_range(0, 2) != 0);
            RX_PERIODIC: i_ready <= ((rx_phase % rx_period) == 0);
            default:     i_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_digest(o_digest);
    end

    // Progress counter for the watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Drive one word; called at a falling edge, returns at a falling edge
    task automatic send_word(t_item w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 100);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= w;
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic [7:0] data, logic valid, logic last);
        t_item w;
        w.data_byte  = data;
        w.byte_valid = valid;
        w.last_byte  = last;
        send_word(w);
        if (valid || last)
            sent_items++;
    endtask

    // Hold off until every digest so far has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // Message of n_bytes; closed by an empty last word or on its final byte
    task automatic send_message(int unsigned n_bytes, bit close_empty);
        for (int unsigned k = 0; k < n_bytes; k++) begin
            // occasional ignored word inside the message
            if ($urandom_range(0, 15) == 0)
                send_fields(8'($urandom), 1'b0, 1'b0);
            send_fields(8'($urandom_range(0, 255)), 1'b1,
                        !close_empty && (k == n_bytes - 1));
        end
        if (close_empty)
            send_fields(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_directed();
        // empty message
        send_fields(8'hFF, 1'b0, 1'b1);
        // single bytes at both extremes
        send_fields(8'h00, 1'b1, 1'b1);
        send_fields(8'hFF, 1'b1, 1'b1);
        // "abc"
        send_fields(8'h61, 1'b1, 1'b0);
        send_fields(8'h62, 1'b1, 1'b0);
        send_fields(8'h63, 1'b1, 1'b1);
        // ignored word mid-message, then closed by an empty last word
        send_fields(8'h61, 1'b1, 1'b0);
        send_fields(8'hA5, 1'b0, 1'b0);
        send_fields(8'h62, 1'b1, 1'b0);
        send_fields(8'h5A, 1'b0, 1'b1);
        // back-to-back empty messages
        send_fields(8'h00, 1'b0, 1'b1);
        send_fields(8'h3C, 1'b0, 1'b1);
    endtask

    task automatic run_random();
        int unsigned n_bytes;
        int          msg_idx;
        bit          close_empty;
        msg_idx = 0;
        while (sent_items < TARGET_ITEMS || msg_idx < MIN_DIGESTS) begin
            // mostly short messages, with padding boundaries favored
            case ($urandom_range(0, 7))
                0, 1: begin
                    case ($urandom_range(0, 12))
                        0:  n_bytes = 0;
                        1:  n_bytes = 1;
                        2:  n_bytes = 54;
                        3:  n_bytes = 55;
                        4:  n_bytes = 56;
                        5:  n_bytes = 57;
                        6:  n_bytes = 63;
                        7:  n_bytes = 64;
                        8:  n_bytes = 65;
                        9:  n_bytes = 119;
                        10: n_bytes = 120;
                        11: n_bytes = 127;
                        default: n_bytes = 128;
                    endcase
                end
                7:       n_bytes = $urandom_range(61, 160);
                default: n_bytes = $urandom_range(0, 60);
            endcase
            close_empty = (n_bytes == 0) || ($urandom_range(0, 3) == 0);
            if (msg_idx == 2 || $urandom_range(0, 9) == 0)
                wait_drained();
            send_message(n_bytes, close_empty);
            msg_idx++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        i_ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                run_directed();
                run_random();
                i_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(negedge i_clk);
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end
            begin
                do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (!timed_out)
            sb.flag_leftovers();
        if (!timed_out && sb.fault_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sha256bsh_pkg.sv
rtl/core/sha256bsh_engine.sv
rtl/core/sha256_byte_stream_hasher_top.sv
dv/testbench.sv
